[sv/frisk_pkg.sv]
// ----------------------------------------------------------------------------
// frisk_pkg
// Shared constants and types of the fuzzy risk inference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frisk_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GRADE_W          = 16;
  localparam int GRADE_QW         = 15;
  localparam int POINT_W          = 16;
  localparam int CLASS_W          = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 48;
  localparam int RULES_W          = 18;
  localparam int LIMIT_W          = 16;
  localparam int NUM_RULES        = 9;

  localparam logic [GRADE_W-1:0] GRADE_ONE = 16'd32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULES      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd6;

  localparam logic [CFG_DATA_W-1:0] WAVE_RESET   = 48'd3298568438016;
  localparam logic [CFG_DATA_W-1:0] SPEED_RESET  = 48'd7696665281280;
  localparam logic [CFG_DATA_W-1:0] DIST_RESET   = 48'd109952421081600;
  localparam logic [CFG_DATA_W-1:0] POINTS_RESET = 48'd87962230465920;
  localparam logic [RULES_W-1:0]    RULES_RESET  = 18'd107137;
  localparam logic [LIMIT_W-1:0]    LOW_RESET    = 16'd7680;
  localparam logic [LIMIT_W-1:0]    HIGH_RESET   = 16'd17920;

  // consequent and class codes
  localparam logic [1:0] CODE_LOW    = 2'd0;
  localparam logic [1:0] CODE_MEDIUM = 2'd1;
  localparam logic [1:0] CODE_HIGH   = 2'd2;

  // where a reading sits against its breakpoints
  typedef struct packed {
    logic le_a;
    logic in_ab;
    logic in_bc;
    logic mid_zero;
    logic le_b;
  } frisk_flags_t;

  localparam int FLAGS_W = $bits(frisk_flags_t);

endpackage

`default_nettype wire

[sv/frisk_ifs.sv]
// ----------------------------------------------------------------------------
// frisk interfaces
// Sample, result and configuration channels of the fuzzy risk unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface frisk_sample_if #(
  parameter int SAMPLE_WIDTH = frisk_pkg::SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] wave_height;
  logic [SAMPLE_WIDTH-1:0] quake_speed;
  logic [SAMPLE_WIDTH-1:0] epicentre_distance;
  modport source (output valid, wave_height, quake_speed, epicentre_distance, input ready);
  modport sink   (input valid, wave_height, quake_speed, epicentre_distance, output ready);
endinterface

interface frisk_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] risk_percent;
  logic [1:0]  risk_class;
  logic [15:0] strength_low;
  logic [15:0] strength_medium;
  logic [15:0] strength_high;
  logic        no_rule_fired;
  modport source (output valid, risk_percent, risk_class, strength_low, strength_medium,
                  strength_high, no_rule_fired, input ready);
  modport sink   (input valid, risk_percent, risk_class, strength_low, strength_medium,
                  strength_high, no_rule_fired, output ready);
endinterface

interface frisk_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [frisk_pkg::CFG_IDX_W-1:0]  index;
  logic [frisk_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/frisk_div.sv]
// ----------------------------------------------------------------------------
// frisk_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
`default_nettype none

module frisk_div #(
  parameter int RW = 16,
  parameter int QW = 15,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [QW-1:0] lo_in,
  input  wire logic [RW-1:0] divisor,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [RW-1:0]      rem_out,
  output logic [TW-1:0]      tag_out
);

  logic          v   [0:QW];
  logic [RW-1:0] rem [0:QW];
  logic [QW-1:0] lo  [0:QW];
  logic [RW-1:0] dv  [0:QW];
  logic [TW-1:0] tag [0:QW];

  logic [RW:0]   trial    [0:QW-1];
  logic [RW-1:0] rem_next [0:QW-1];
  logic [QW-1:0] lo_next  [0:QW-1];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rem[k], lo[k][QW-1]};
      if (trial[k] >= {1'b0, dv[k]}) begin
        rem_next[k] = RW'(trial[k] - {1'b0, dv[k]});
        lo_next[k]  = {lo[k][QW-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[k][RW-1:0];
        lo_next[k]  = {lo[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int k = 0; k < QW; k++) v[k+1] <= v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem_in;
      lo[0]  <= lo_in;
      dv[0]  <= divisor;
      tag[0] <= tag_in;
      for (int k = 0; k < QW; k++) begin
        rem[k+1] <= rem_next[k];
        lo[k+1]  <= lo_next[k];
        dv[k+1]  <= dv[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = lo[QW];
  assign rem_out   = rem[QW];
  assign tag_out   = tag[QW];

endmodule

`default_nettype wire

[sv/three_input_fuzzy_risk_inference_unit.sv]
// ----------------------------------------------------------------------------
// three_input_fuzzy_risk_inference_unit
// Grades three readings, fires nine min rules, max-aggregates and takes the
// rounded weighted average of three singletons, then classes the risk.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the result is not stalled; the 15-stage grade dividers and the
//   16-stage risk divider are fully pipelined
// a stalled result stalls the whole pipeline, nothing is lost or repeated
// reset: synchronous, clears valid bits and loads register defaults
`default_nettype none

module three_input_fuzzy_risk_inference_unit #(
  parameter int SAMPLE_WIDTH = frisk_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  frisk_sample_if.sink samples,
  frisk_result_if.source results,
  frisk_cfg_if.sink  cfg
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int GW  = frisk_pkg::GRADE_W;
  localparam int QGW = frisk_pkg::GRADE_QW;
  localparam int FW  = frisk_pkg::FLAGS_W;
  localparam int SUM_W = 17;
  localparam int NUM_W = 33;
  localparam int TAG_W = 3 * GW + 1;

  // configuration registers
  logic [frisk_pkg::CFG_DATA_W-1:0] bp [0:2];
  logic [frisk_pkg::CFG_DATA_W-1:0] points;
  logic [frisk_pkg::RULES_W-1:0]    rules;
  logic [frisk_pkg::LIMIT_W-1:0]    low_limit;
  logic [frisk_pkg::LIMIT_W-1:0]    high_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bp[0]      <= frisk_pkg::WAVE_RESET;
      bp[1]      <= frisk_pkg::SPEED_RESET;
      bp[2]      <= frisk_pkg::DIST_RESET;
      points     <= frisk_pkg::POINTS_RESET;
      rules      <= frisk_pkg::RULES_RESET;
      low_limit  <= frisk_pkg::LOW_RESET;
      high_limit <= frisk_pkg::HIGH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        frisk_pkg::REG_WAVE:       bp[0]      <= cfg.data;
        frisk_pkg::REG_SPEED:      bp[1]      <= cfg.data;
        frisk_pkg::REG_DIST:       bp[2]      <= cfg.data;
        frisk_pkg::REG_POINTS:     points     <= cfg.data;
        frisk_pkg::REG_RULES:      rules      <= cfg.data[frisk_pkg::RULES_W-1:0];
        frisk_pkg::REG_LOW_LIMIT:  low_limit  <= cfg.data[frisk_pkg::LIMIT_W-1:0];
        frisk_pkg::REG_HIGH_LIMIT: high_limit <= cfg.data[frisk_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves when the output slot is free or taken
  logic out_v;
  logic en;
  assign en = !out_v || results.ready;
  assign samples.ready = en;

  // stage 0: input register
  logic          s0_v;
  logic [SW-1:0] s0_x [0:2];

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= samples.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x[0] <= samples.wave_height;
      s0_x[1] <= samples.quake_speed;
      s0_x[2] <= samples.epicentre_distance;
    end
  end

  // breakpoint compare and ramp setup, then grade dividers
  logic [SW-1:0]  ga [0:2];
  logic [SW-1:0]  gb [0:2];
  logic [SW-1:0]  gc [0:2];
  logic [SW-1:0]  dn [0:2];
  logic [SW-1:0]  dd [0:2];
  frisk_pkg::frisk_flags_t fl [0:2];
  logic [2:0]     gv;
  logic [QGW-1:0] gq [0:2];
  logic [SW-1:0]  gr [0:2];
  logic [FW-1:0]  gt [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ga[j] = SW'(64'(bp[j]));
      gb[j] = SW'(64'(bp[j]) >> SW);
      gc[j] = SW'(64'(bp[j]) >> (2 * SW));
      fl[j].le_a     = s0_x[j] <= ga[j];
      fl[j].le_b     = s0_x[j] <= gb[j];
      fl[j].in_ab    = !fl[j].le_a && (s0_x[j] < gb[j]);
      fl[j].in_bc    = !fl[j].le_b && (s0_x[j] < gc[j]);
      fl[j].mid_zero = fl[j].le_a || (s0_x[j] >= gc[j]);
      if (fl[j].in_ab) begin
        dn[j] = gb[j] - s0_x[j];
        dd[j] = gb[j] - ga[j];
      end else if (fl[j].in_bc) begin
        dn[j] = s0_x[j] - gb[j];
        dd[j] = gc[j] - gb[j];
      end else begin
        dn[j] = '0;
        dd[j] = SW'(1);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_grade
    frisk_div #(.RW(SW), .QW(QGW), .TW(FW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (s0_v),
      .rem_in   (dn[j]),
      .lo_in    ('0),
      .divisor  (dd[j]),
      .tag_in   (fl[j]),
      .out_valid(gv[j]),
      .quot     (gq[j]),
      .rem_out  (gr[j]),
      .tag_out  (gt[j])
    );
  end

  // stage G: membership grades
  logic          g_v;
  logic [GW-1:0] gl [0:2];
  logic [GW-1:0] gm [0:2];
  logic [GW-1:0] gh [0:2];
  logic [GW-1:0] gl_next [0:2];
  logic [GW-1:0] gm_next [0:2];
  logic [GW-1:0] gh_next [0:2];
  frisk_pkg::frisk_flags_t gf [0:2];
  logic [GW-1:0] ramp [0:2];
  logic [GW-1:0] comp [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      gf[j]   = gt[j];
      ramp[j] = GW'(gq[j]);
      // complementary ramp is one minus the ceiling of the divided ramp
      comp[j] = frisk_pkg::GRADE_ONE - ramp[j] - GW'(gr[j] != '0);
      if (gf[j].le_a) gl_next[j] = frisk_pkg::GRADE_ONE;
      else if (gf[j].in_ab) gl_next[j] = ramp[j];
      else gl_next[j] = '0;
      if (gf[j].mid_zero) gm_next[j] = '0;
      else if (gf[j].in_ab || gf[j].in_bc) gm_next[j] = comp[j];
      else gm_next[j] = frisk_pkg::GRADE_ONE;
      if (gf[j].le_b) gh_next[j] = '0;
      else if (gf[j].in_bc) gh_next[j] = ramp[j];
      else gh_next[j] = frisk_pkg::GRADE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (en) g_v <= &gv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        gl[j] <= gl_next[j];
        gm[j] <= gm_next[j];
        gh[j] <= gh_next[j];
      end
    end
  end

  // stage M: rule firing strengths by three-way minimum
  logic          m_v;
  logic [GW-1:0] w [0:frisk_pkg::NUM_RULES-1];
  logic [GW-1:0] w_next [0:frisk_pkg::NUM_RULES-1];
  logic [GW-1:0] g1 [0:2];
  logic [GW-1:0] g2 [0:2];
  logic [GW-1:0] g3 [0:2];
  logic [GW-1:0] t12;

  always_comb begin
    g1[0] = gl[0]; g1[1] = gm[0]; g1[2] = gh[0];
    g2[0] = gl[1]; g2[1] = gm[1]; g2[2] = gh[1];
    g3[0] = gl[2]; g3[1] = gm[2]; g3[2] = gh[2];
    t12 = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        t12 = (g1[i] < g2[k]) ? g1[i] : g2[k];
        w_next[3*i+k] = (t12 < g3[k]) ? t12 : g3[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= g_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < frisk_pkg::NUM_RULES; r++) w[r] <= w_next[r];
    end
  end

  // stage A: max aggregation per conclusion
  logic          a_v;
  logic [GW-1:0] st [0:2];
  logic [GW-1:0] st_next [0:2];
  logic [1:0]    code [0:frisk_pkg::NUM_RULES-1];

  always_comb begin
    for (int r = 0; r < frisk_pkg::NUM_RULES; r++) code[r] = rules[2*r +: 2];
    for (int c = 0; c < 3; c++) begin
      st_next[c] = '0;
      for (int r = 0; r < frisk_pkg::NUM_RULES; r++) begin
        if (code[r] == 2'(c) && w[r] > st_next[c]) st_next[c] = w[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= m_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) st[c] <= st_next[c];
    end
  end

  // stage P: weighted products and strength sum
  logic             p_v;
  logic [31:0]      prod [0:2];
  logic [GW-1:0]    p_st [0:2];
  logic [SUM_W-1:0] p_sum;

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= 32'(st[c]) * 32'(points[frisk_pkg::POINT_W*c +: frisk_pkg::POINT_W]);
        p_st[c] <= st[c];
      end
      p_sum <= SUM_W'(st[frisk_pkg::CODE_LOW]) + SUM_W'(st[frisk_pkg::CODE_MEDIUM])
             + SUM_W'(st[frisk_pkg::CODE_HIGH]);
    end
  end

  // rounded numerator into the risk divider; its quotient fits in 16 bits
  logic [NUM_W-1:0] dvd;
  logic [TAG_W-1:0] rtag_in;
  logic             rv;
  logic [15:0]      rq;
  logic [SUM_W-1:0] rr;
  logic [TAG_W-1:0] rtag;

  assign dvd = NUM_W'(prod[0]) + NUM_W'(prod[1]) + NUM_W'(prod[2]) + NUM_W'(p_sum >> 1);
  assign rtag_in = {p_sum == '0, p_st[2], p_st[1], p_st[0]};

  frisk_div #(.RW(SUM_W), .QW(16), .TW(TAG_W)) u_risk_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_v),
    .rem_in   (dvd[NUM_W-1:16]),
    .lo_in    (dvd[15:0]),
    .divisor  (p_sum),
    .tag_in   (rtag_in),
    .out_valid(rv),
    .quot     (rq),
    .rem_out  (rr),
    .tag_out  (rtag)
  );

  // stage C: classing and output register
  logic        nrf;
  logic [15:0] risk;
  logic [1:0]  cls;

  assign nrf  = rtag[TAG_W-1];
  assign risk = nrf ? 16'd0 : rq;

  always_comb begin
    if (risk <= low_limit) cls = frisk_pkg::CODE_LOW;
    else if (risk <= high_limit) cls = frisk_pkg::CODE_MEDIUM;
    else cls = frisk_pkg::CODE_HIGH;
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= rv;
  end

  // remainder of the risk division is not needed beyond this point
  logic rr_unused;
  assign rr_unused = ^rr;

  always_ff @(posedge clk) begin
    if (en) begin
      results.risk_percent    <= risk;
      results.risk_class      <= cls;
      results.strength_low    <= rtag[0 +: GW];
      results.strength_medium <= rtag[GW +: GW];
      results.strength_high   <= rtag[2*GW +: GW];
      results.no_rule_fired   <= nrf ^ (rr_unused & 1'b0);
    end
  end

  assign results.valid = out_v;

endmodule

`default_nettype wire

[sv/frisk_checker.sv]
// ----------------------------------------------------------------------------
// frisk_checker
// Port-level checks on the result channel of the fuzzy risk unit.
// ----------------------------------------------------------------------------
`default_nettype none

module frisk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] risk_percent,
  input wire logic [1:0]  risk_class,
  input wire logic [15:0] strength_low,
  input wire logic [15:0] strength_medium,
  input wire logic [15:0] strength_high,
  input wire logic        no_rule_fired
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(risk_percent))
    else $error("result dropped or changed while stalled");

  a_no_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_rule_fired |-> risk_percent == 16'd0 && risk_class == 2'd0)
    else $error("no rule fired but risk is not zero");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> no_rule_fired == (strength_low == 16'd0 && strength_medium == 16'd0
                                    && strength_high == 16'd0))
    else $error("no_rule_fired disagrees with strengths");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> strength_low <= 16'd32768 && strength_medium <= 16'd32768
                  && strength_high <= 16'd32768 && risk_class != 2'd3)
    else $error("strength or class out of range");

endmodule

bind three_input_fuzzy_risk_inference_unit frisk_checker u_frisk_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .risk_percent   (results.risk_percent),
  .risk_class     (results.risk_class),
  .strength_low   (results.strength_low),
  .strength_medium(results.strength_medium),
  .strength_high  (results.strength_high),
  .no_rule_fired  (results.no_rule_fired)
);

`default_nettype wire
